[design/gse_pkg.sv]
// gse_pkg: shared types, constants and exponent tables for the gaussian sum evaluator
// no dependencies
`default_nettype none

package gse_pkg;

  // number of register stages inside one lane
  localparam int unsigned LANE_STAGES = 7;
  // gaussians that own configuration registers
  localparam int unsigned CFG_GAUSS   = 3;

  localparam logic [18:0] R_CLAMP     = 19'd393216;   // 6.0 in Q16.16
  localparam logic [21:0] ARG_LIMIT   = 22'd1048576;  // 16.0 in Q.16
  localparam logic [17:0] DENSITY_MAX = 18'd262143;

  // configuration register indexes
  localparam logic [2:0] REG_G0_AMP_CENTER = 3'd0;
  localparam logic [2:0] REG_G0_INV_SPREAD = 3'd1;
  localparam logic [2:0] REG_G1_AMP_CENTER = 3'd2;
  localparam logic [2:0] REG_G1_INV_SPREAD = 3'd3;
  localparam logic [2:0] REG_G2_AMP_CENTER = 3'd4;
  localparam logic [2:0] REG_G2_INV_SPREAD = 3'd5;

  // per-stage load enables from the pipeline control
  typedef struct packed {
    logic [LANE_STAGES-1:0] load;
  } gse_pipe_t;

  // round(exp(-n) * 2^16), n = 0..16
  function automatic logic [16:0] exp_int(input logic [4:0] n);
    logic [16:0] v;
    case (n)
      5'd0:    v = 17'd65536;
      5'd1:    v = 17'd24109;
      5'd2:    v = 17'd8869;
      5'd3:    v = 17'd3263;
      5'd4:    v = 17'd1200;
      5'd5:    v = 17'd442;
      5'd6:    v = 17'd162;
      5'd7:    v = 17'd60;
      5'd8:    v = 17'd22;
      5'd9:    v = 17'd8;
      5'd10:   v = 17'd3;
      5'd11:   v = 17'd1;
      default: v = 17'd0;
    endcase
    return v;
  endfunction

  // round(exp(-k/16) * 2^16), k = 0..15
  function automatic logic [16:0] exp_frac(input logic [3:0] k);
    logic [16:0] v;
    case (k)
      4'd0:    v = 17'd65536;
      4'd1:    v = 17'd61565;
      4'd2:    v = 17'd57835;
      4'd3:    v = 17'd54331;
      4'd4:    v = 17'd51039;
      4'd5:    v = 17'd47947;
      4'd6:    v = 17'd45042;
      4'd7:    v = 17'd42313;
      4'd8:    v = 17'd39750;
      4'd9:    v = 17'd37341;
      4'd10:   v = 17'd35079;
      4'd11:   v = 17'd32954;
      4'd12:   v = 17'd30957;
      4'd13:   v = 17'd29081;
      4'd14:   v = 17'd27319;
      default: v = 17'd25664;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

[design/gse_lane.sv]
// gse_lane: seven-stage pipeline giving one weighted gaussian contribution
// depends on gse_pkg
`default_nettype none

module gse_lane (
  input  wire logic              clk_i,
  input  wire gse_pkg::gse_pipe_t pipe_i,
  input  wire logic signed [15:0] pos_x_i,
  input  wire logic signed [15:0] pos_y_i,
  input  wire logic [47:0]       amp_center_i,
  input  wire logic [31:0]       inv_spread_i,
  output logic [15:0]            contrib_o
);

  logic [15:0] amp, mean_x, mean_y, inv_x, inv_y;
  assign amp    = amp_center_i[47:32];
  assign mean_x = amp_center_i[31:16];
  assign mean_y = amp_center_i[15:0];
  assign inv_x  = inv_spread_i[31:16];
  assign inv_y  = inv_spread_i[15:0];

  // stage 1: absolute offsets
  logic signed [16:0] dx, dy;
  logic [16:0] adx, ady;
  logic [15:0] mag_x_q, mag_y_q;
  assign dx  = 17'(pos_x_i) - 17'($signed(mean_x));
  assign dy  = 17'(pos_y_i) - 17'($signed(mean_y));
  assign adx = dx[16] ? 17'(-dx) : 17'(dx);
  assign ady = dy[16] ? 17'(-dy) : 17'(dy);
  always_ff @(posedge clk_i) begin
    if (pipe_i.load[0]) begin
      mag_x_q <= adx[15:0];
      mag_y_q <= ady[15:0];
    end
  end

  // stage 2: scale by reciprocal sigma and clamp
  logic [31:0] prod_x, prod_y;
  logic [18:0] r_x_q, r_y_q;
  assign prod_x = mag_x_q * inv_x;
  assign prod_y = mag_y_q * inv_y;
  always_ff @(posedge clk_i) begin
    if (pipe_i.load[1]) begin
      r_x_q <= (prod_x > 32'(gse_pkg::R_CLAMP)) ? gse_pkg::R_CLAMP : prod_x[18:0];
      r_y_q <= (prod_y > 32'(gse_pkg::R_CLAMP)) ? gse_pkg::R_CLAMP : prod_y[18:0];
    end
  end

  // stage 3: squares
  logic [37:0] sq_x_q, sq_y_q;
  always_ff @(posedge clk_i) begin
    if (pipe_i.load[2]) begin
      sq_x_q <= 38'(r_x_q) * 38'(r_x_q);
      sq_y_q <= 38'(r_y_q) * 38'(r_y_q);
    end
  end

  // stage 4: halved argument and far test
  logic [38:0] sq_sum;
  logic [21:0] arg;
  logic [20:0] arg_q;
  logic        far4_q;
  assign sq_sum = 39'(sq_x_q) + 39'(sq_y_q);
  assign arg    = sq_sum[38:17];
  always_ff @(posedge clk_i) begin
    if (pipe_i.load[3]) begin
      arg_q  <= arg[20:0];
      far4_q <= arg > gse_pkg::ARG_LIMIT;
    end
  end

  // stage 5: table product and correction polynomial
  logic [33:0] tab_prod;
  logic [23:0] f_sq;
  logic [11:0] frac;
  logic [16:0] e1_q, poly_q;
  logic        far5_q;
  assign frac     = arg_q[11:0];
  assign tab_prod = 34'(gse_pkg::exp_int(arg_q[20:16])) *
                    34'(gse_pkg::exp_frac(arg_q[15:12])) + 34'd32768;
  assign f_sq     = 24'(frac) * 24'(frac);
  always_ff @(posedge clk_i) begin
    if (pipe_i.load[4]) begin
      e1_q   <= tab_prod[32:16];
      poly_q <= 17'(18'd65536 - 18'(frac) + 18'(f_sq[23:17]));
      far5_q <= far4_q;
    end
  end

  // stage 6: apply polynomial
  logic [34:0] e_prod;
  logic [16:0] e_q;
  logic        far6_q;
  assign e_prod = 35'(e1_q) * 35'(poly_q) + 35'd32768;
  always_ff @(posedge clk_i) begin
    if (pipe_i.load[5]) begin
      e_q    <= e_prod[32:16];
      far6_q <= far5_q;
    end
  end

  // stage 7: weight by amplitude
  logic [33:0] w_prod;
  logic [15:0] contrib_q;
  assign w_prod = 34'(amp) * 34'(e_q) + 34'd32768;
  always_ff @(posedge clk_i) begin
    if (pipe_i.load[6]) begin
      contrib_q <= far6_q ? 16'd0 : w_prod[31:16];
    end
  end

  assign contrib_o = contrib_q;

endmodule

`default_nettype wire

[design/gaussian_sum_2d_eval.sv]
// each accepted input word passes the seven lane stages and then the output register
// throughput: one word per cycle while the output is not stalled; each lane is a seven-stage multiply pipeline
// stalls close only full stages, so bubbles are squeezed out under back-pressure
// reset clears valid bits and configuration registers (all zero)
// depends on gse_pkg and gse_lane
`default_nettype none

module gaussian_sum_2d_eval #(
  parameter int unsigned NUM_GAUSSIANS = 3
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_we_i,
  input  wire logic [2:0]        cfg_idx_i,
  input  wire logic [47:0]       cfg_data_i,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire logic signed [15:0] pos_x_i,
  input  wire logic signed [15:0] pos_y_i,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output logic [17:0]            density_o,
  output logic                   clipped_o
);

  localparam int unsigned NS = gse_pkg::LANE_STAGES + 1;

  // configuration registers
  logic [47:0] amp_center_q [gse_pkg::CFG_GAUSS];
  logic [31:0] inv_spread_q [gse_pkg::CFG_GAUSS];
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int g = 0; g < int'(gse_pkg::CFG_GAUSS); g++) begin
        amp_center_q[g] <= '0;
        inv_spread_q[g] <= '0;
      end
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        gse_pkg::REG_G0_AMP_CENTER: amp_center_q[0] <= cfg_data_i;
        gse_pkg::REG_G0_INV_SPREAD: inv_spread_q[0] <= cfg_data_i[31:0];
        gse_pkg::REG_G1_AMP_CENTER: amp_center_q[1] <= cfg_data_i;
        gse_pkg::REG_G1_INV_SPREAD: inv_spread_q[1] <= cfg_data_i[31:0];
        gse_pkg::REG_G2_AMP_CENTER: amp_center_q[2] <= cfg_data_i;
        gse_pkg::REG_G2_INV_SPREAD: inv_spread_q[2] <= cfg_data_i[31:0];
        default: ;
      endcase
    end
  end

  // pipeline valid bits and load chain
  logic [NS-1:0] valid_q, valid_d, rdy;
  always_comb begin
    rdy[NS-1] = !valid_q[NS-1] || !out_stall_i;
    for (int i = NS - 2; i >= 0; i--) begin
      rdy[i] = !valid_q[i] || rdy[i+1];
    end
    valid_d = valid_q;
    valid_d[0] = rdy[0] ? in_valid_i : valid_q[0];
    for (int i = 1; i < NS; i++) begin
      if (rdy[i]) begin
        valid_d[i] = valid_q[i-1];
      end
    end
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  gse_pkg::gse_pipe_t pipe;
  assign pipe.load = rdy[gse_pkg::LANE_STAGES-1:0];
  assign in_stall_o = !rdy[0];

  // one lane per gaussian; a lane without registers sees zeros
  logic [15:0] contrib [NUM_GAUSSIANS];
  for (genvar g = 0; g < NUM_GAUSSIANS; g++) begin : g_lane
    logic [47:0] ac;
    logic [31:0] is;
    if (g < gse_pkg::CFG_GAUSS) begin : g_cfg
      assign ac = amp_center_q[g];
      assign is = inv_spread_q[g];
    end else begin : g_nocfg
      assign ac = '0;
      assign is = '0;
    end
    gse_lane u_lane (
      .clk_i        (clk_i),
      .pipe_i       (pipe),
      .pos_x_i      (pos_x_i),
      .pos_y_i      (pos_y_i),
      .amp_center_i (ac),
      .inv_spread_i (is),
      .contrib_o    (contrib[g])
    );
  end

  // sum and saturate into the output word
  logic [18:0] sum;
  logic [17:0] density_q;
  logic        clipped_q;
  always_comb begin
    sum = '0;
    for (int g = 0; g < NUM_GAUSSIANS; g++) begin
      sum = sum + 19'(contrib[g]);
    end
  end
  always_ff @(posedge clk_i) begin
    if (rdy[NS-1]) begin
      density_q <= sum[18] ? gse_pkg::DENSITY_MAX : sum[17:0];
      clipped_q <= sum[18];
    end
  end

  assign out_valid_o = valid_q[NS-1];
  assign density_o   = density_q;
  assign clipped_o   = clipped_q;

endmodule

`default_nettype wire

[test/gaussian_sum_2d_eval_test.sv]
// testbench for gaussian_sum_2d_eval: random and directed points checked against
// a bit-exact predictor of the three-gaussian density; depends on gse_pkg and the block
`timescale 1ns / 100ps

class density_board;
  logic [17:0] want_density[$];
  logic        want_clipped[$];
  logic [47:0] amp_center[4];
  logic [31:0] inv_spread[4];
  int          mismatches;

  function void clear_regs();
    for (int g = 0; g < 4; g++) begin
      amp_center[g] = '0;
      inv_spread[g] = '0;
    end
  endfunction

  function void write_reg(logic [2:0] idx, logic [47:0] val);
    if (idx <= gse_pkg::REG_G2_INV_SPREAD) begin
      if (idx[0]) inv_spread[idx >> 1] = val[31:0];
      else amp_center[idx >> 1] = val;
    end
  endfunction

  // |pos - mean| times reciprocal sigma, clamped to 6.0 in Q16.16
  function logic [63:0] scaled(logic [15:0] p, logic [15:0] m, logic [15:0] inv);
    int d;
    logic [63:0] r;
    d = $signed(p) - $signed(m);
    if (d < 0) d = -d;
    r = 64'(d) * 64'(inv);
    return (r > 64'd393216) ? 64'd393216 : r;
  endfunction

  function logic [63:0] exp_tab_int(int n);
    logic [63:0] t[17] = '{65536, 24109, 8869, 3263, 1200, 442, 162, 60, 22, 8, 3, 1,
                            0, 0, 0, 0, 0};
    return t[n];
  endfunction

  function logic [63:0] exp_tab_frac(int k);
    logic [63:0] t[16] = '{65536, 61565, 57835, 54331, 51039, 47947, 45042, 42313,
                            39750, 37341, 35079, 32954, 30957, 29081, 27319, 25664};
    return t[k];
  endfunction

  function logic [63:0] weighted_term(int g, logic [15:0] px, logic [15:0] py);
    logic [63:0] r1, r2, a, f, poly, e;
    r1 = scaled(px, amp_center[g][31:16], inv_spread[g][31:16]);
    r2 = scaled(py, amp_center[g][15:0], inv_spread[g][15:0]);
    a = (r1 * r1 + r2 * r2) >> 17;
    if (a > 64'd1048576) return 0;
    f = a & 64'hFFF;
    poly = 64'd65536 - f + ((f * f) >> 17);
    e = (exp_tab_int(int'(a >> 16)) * exp_tab_frac(int'((a >> 12) & 15)) + 32768) >> 16;
    e = (e * poly + 32768) >> 16;
    return (64'(amp_center[g][47:32]) * e + 32768) >> 16;
  endfunction

  // note an accepted point
  function void note_point(logic [15:0] px, logic [15:0] py);
    logic [63:0] sum;
    sum = 0;
    for (int g = 0; g < 3; g++) sum += weighted_term(g, px, py);
    if (sum > 64'd262143) begin
      want_density.push_back(18'd262143);
      want_clipped.push_back(1'b1);
    end else begin
      want_density.push_back(sum[17:0]);
      want_clipped.push_back(1'b0);
    end
  endfunction

  // check an accepted result word
  function void check_word(logic [17:0] dens, logic clip);
    logic [17:0] wd;
    logic        wc;
    if (want_density.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected word: density %0d clipped %0b", dens, clip);
      return;
    end
    wd = want_density.pop_front();
    wc = want_clipped.pop_front();
    if (wd !== dens || wc !== clip) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch: density exp %0d got %0d, clipped exp %0b got %0b",
                 wd, dens, wc, clip);
    end
  endfunction
endclass

module gaussian_sum_2d_eval_test;

  logic clk_i = 0, rst_ni = 0;
  logic cfg_we_i = 0;
  logic [2:0] cfg_idx_i = '0;
  logic [47:0] cfg_data_i = '0;
  logic in_valid_i = 0, in_stall_o;
  logic signed [15:0] pos_x_i = '0, pos_y_i = '0;
  logic out_valid_o, out_stall_i = 0;
  logic [17:0] density_o;
  logic clipped_o;

  density_board board;
  int send_idle_pct = 0, recv_idle_pct = 0;
  int unsigned cycles = 0;
  localparam int unsigned CYCLE_LIMIT = 200000;

  gaussian_sum_2d_eval DUT (.*);

  // clock
  always begin
    #5 clk_i = 1;
    #5 clk_i = 0;
  end

  // watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // receiver: random stall and result check
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) board.check_word(density_o, clipped_o);
      out_stall_i <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // one register write, enable dropped for a cycle after it
  task automatic write_reg(logic [2:0] idx, logic [47:0] val);
    cfg_we_i <= 1; cfg_idx_i <= idx; cfg_data_i <= val;
    @(posedge clk_i);
    board.write_reg(idx, val);
    cfg_we_i <= 0;
    @(posedge clk_i);
  endtask

  // send one point word, holding until accepted; valid stays high for a following word
  task automatic send_point(logic [15:0] px, logic [15:0] py);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 0;
      @(posedge clk_i);
    end
    in_valid_i <= 1; pos_x_i <= px; pos_y_i <= py;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    board.note_point(px, py);
  endtask

  task automatic drain();
    in_valid_i <= 0;
    while (board.want_density.size() != 0) @(posedge clk_i);
    repeat (12) @(posedge clk_i);
  endtask

  // random gaussian set; sizes from wide to extreme
  task automatic random_regs(int mode);
    logic [15:0] amp, inv_x, inv_y;
    for (int g = 0; g < 3; g++) begin
      amp = (mode == 0) ? 16'hFFFF : 16'($urandom);
      inv_x = (mode == 1) ? 16'h0000 : (mode == 0) ? 16'hFFFF : 16'($urandom_range(16, 1024));
      inv_y = (mode == 1) ? 16'($urandom_range(16, 600)) : (mode == 0) ? 16'hFFFF
              : 16'($urandom_range(16, 1024));
      write_reg(3'(2 * g), {amp, 16'($urandom), 16'($urandom)});
      write_reg(3'(2 * g + 1), {16'($urandom), inv_x, inv_y});
    end
  endtask

  // point near a random centre, sometimes anywhere
  task automatic random_point();
    int g;
    logic [15:0] mx, my;
    g = $urandom_range(2);
    mx = board.amp_center[g][31:16];
    my = board.amp_center[g][15:0];
    if ($urandom_range(9) < 2) send_point(16'($urandom), 16'($urandom));
    else send_point(mx + 16'($signed($urandom_range(2047)) - 1024),
                    my + 16'($signed($urandom_range(2047)) - 1024));
  endtask

  initial begin
    board = new();
    board.clear_regs();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // directed: all-zero registers, then a unit gaussian at the origin, a corner one and a flat one
    send_point(16'h8000, 16'h7FFF);
    drain();
    write_reg(gse_pkg::REG_G0_AMP_CENTER, {16'hFFFF, 16'h0000, 16'h0000});
    write_reg(gse_pkg::REG_G0_INV_SPREAD, {16'h0000, 16'h0100, 16'h0100});
    write_reg(gse_pkg::REG_G1_AMP_CENTER, {16'hFFFF, 16'h7FFF, 16'h8000});
    write_reg(gse_pkg::REG_G1_INV_SPREAD, {16'h0000, 16'hFFFF, 16'h0000});
    write_reg(gse_pkg::REG_G2_AMP_CENTER, {16'hFFFF, 16'h0000, 16'h0000});
    write_reg(gse_pkg::REG_G2_INV_SPREAD, {16'h0000, 16'h0000, 16'h0000});
    write_reg(3'd7, 48'hFFFF_FFFF_FFFF);  // bad index, ignored
    send_point(16'h0000, 16'h0000);
    send_point(16'h7FFF, 16'h8000);
    send_point(16'h8000, 16'h7FFF);
    send_point(16'h0100, 16'hFF00);
    send_point(16'h0400, 16'h0000);
    send_point(16'h05A8, 16'h0000);
    send_point(16'h0600, 16'h0000);
    send_point(16'h0000, 16'h0601);
    send_point(16'h7FFF, 16'h7F00);
    send_point(16'hFFFF, 16'h0001);
    for (int i = 0; i < 10; i++) send_point(16'(i * 100), 16'(-i * 77));
    drain();

    // random phases under the three idling mixes
    for (int ph = 0; ph < 6; ph++) begin
      random_regs(ph % 3);
      send_idle_pct = (ph < 2) ? 9 : (ph < 4) ? 50 : 0;
      recv_idle_pct = (ph < 2) ? 50 : (ph < 4) ? 9 : 0;
      for (int i = 0; i < 140; i++) begin
        random_point();
        if (i == 70) drain();
      end
      drain();
    end

    if (board.mismatches == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end
endmodule
